// File: rtl/tcpq_pkg.sv
package tcpq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_SERVE   = 1'b1;

   localparam logic CLASS_PRIORITY = 1'b0;
   localparam logic CLASS_COMMON   = 1'b1;

   localparam logic [1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [1:0] STATUS_SERVED   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef struct packed {
      logic       func;
      logic       ticket_class;
      logic [7:0] ticket_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] served_value;
      logic       served_class;
      logic [4:0] priority_count;
      logic [4:0] common_count;
   } rsp_type;

endpackage

// File: rtl/two_class_priority_queue.sv
// Strict-priority scheduler over two FIFO ticket queues of QUEUE_DEPTH entries
// each. A transaction is taken at every clock edge where start is high; busy
// stays low, so one enqueue or serve can be issued in every cycle. Each
// transaction yields exactly one result, presented for a single cycle with
// rsp_strobe high once the registered transaction has updated the queues. The
// transaction is registered first, and at the next edge the queue pointers,
// the counts, the status and the read of the ticket memories all update
// together. The receiver cannot stall, so it must capture each result in the
// cycle its strobe is high. Results come out in issue order, and the counts in
// a result give the occupancy of both queues just after that step.
module two_class_priority_queue #(
   parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcpq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tcpq_pkg::rsp_type rsp_data
);
   import tcpq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;

   req_type            req_ff;
   logic               req_valid_ff;

   logic [PTR_W-1:0]   prio_head_ff, prio_head_in;
   logic [PTR_W-1:0]   common_head_ff, common_head_in;
   logic [CNT_W-1:0]   prio_fill_ff, prio_fill_in;
   logic [CNT_W-1:0]   common_fill_ff, common_fill_in;

   logic [7:0]         prio_mem [QUEUE_DEPTH];
   logic [7:0]         common_mem [QUEUE_DEPTH];
   logic [7:0]         prio_rd_ff;
   logic [7:0]         common_rd_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_class_ff, rsp_class_in;
   logic               rsp_served_ff, rsp_served_in;

   logic               push_prio, push_common, pop_prio, pop_common;
   logic               prio_full, common_full, prio_empty, common_empty;
   logic [SUM_W-1:0]   prio_sum, common_sum;
   logic [PTR_W-1:0]   prio_wr_addr, common_wr_addr;
   logic [CNT_W+4:0]   prio_count_ext, common_count_ext;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   assign prio_full    = (prio_fill_ff == CNT_W'(QUEUE_DEPTH));
   assign common_full  = (common_fill_ff == CNT_W'(QUEUE_DEPTH));
   assign prio_empty   = (prio_fill_ff == '0);
   assign common_empty = (common_fill_ff == '0);

   always_comb begin
      push_prio     = 1'b0;
      push_common   = 1'b0;
      pop_prio      = 1'b0;
      pop_common    = 1'b0;
      rsp_status_in = STATUS_EMPTY;
      rsp_class_in  = CLASS_PRIORITY;
      rsp_served_in = 1'b0;
      if (req_ff.func == FUNC_ENQUEUE) begin
         if (req_ff.ticket_class == CLASS_PRIORITY) begin
            push_prio     = req_valid_ff && !prio_full;
            rsp_status_in = prio_full ? STATUS_DROPPED : STATUS_ENQUEUED;
         end else begin
            push_common   = req_valid_ff && !common_full;
            rsp_status_in = common_full ? STATUS_DROPPED : STATUS_ENQUEUED;
         end
      end else if (!prio_empty) begin
         pop_prio      = req_valid_ff;
         rsp_status_in = STATUS_SERVED;
         rsp_served_in = 1'b1;
      end else if (!common_empty) begin
         pop_common    = req_valid_ff;
         rsp_status_in = STATUS_SERVED;
         rsp_class_in  = CLASS_COMMON;
         rsp_served_in = 1'b1;
      end
   end

   always_comb begin
      prio_sum   = SUM_W'(prio_head_ff) + SUM_W'(prio_fill_ff);
      common_sum = SUM_W'(common_head_ff) + SUM_W'(common_fill_ff);
      if (prio_sum >= SUM_W'(QUEUE_DEPTH)) begin
         prio_sum = prio_sum - SUM_W'(QUEUE_DEPTH);
      end
      if (common_sum >= SUM_W'(QUEUE_DEPTH)) begin
         common_sum = common_sum - SUM_W'(QUEUE_DEPTH);
      end
      prio_wr_addr   = prio_sum[PTR_W-1:0];
      common_wr_addr = common_sum[PTR_W-1:0];
   end

   always_comb begin
      prio_head_in   = prio_head_ff;
      common_head_in = common_head_ff;
      prio_fill_in   = prio_fill_ff;
      common_fill_in = common_fill_ff;
      if (pop_prio) begin
         prio_head_in = (prio_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : prio_head_ff + 1'b1;
         prio_fill_in = prio_fill_ff - 1'b1;
      end
      if (pop_common) begin
         common_head_in = (common_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : common_head_ff + 1'b1;
         common_fill_in = common_fill_ff - 1'b1;
      end
      if (push_prio) begin
         prio_fill_in = prio_fill_ff + 1'b1;
      end
      if (push_common) begin
         common_fill_in = common_fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_head_ff   <= '0;
         common_head_ff <= '0;
         prio_fill_ff   <= '0;
         common_fill_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prio_head_ff   <= prio_head_in;
         common_head_ff <= common_head_in;
         prio_fill_ff   <= prio_fill_in;
         common_fill_ff <= common_fill_in;
         rsp_valid_ff   <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_served_ff <= rsp_served_in;
   end

   always_ff @(posedge clock) begin
      if (push_prio) begin
         prio_mem[prio_wr_addr] <= req_ff.ticket_value;
      end
      prio_rd_ff <= prio_mem[prio_head_ff];
   end

   always_ff @(posedge clock) begin
      if (push_common) begin
         common_mem[common_wr_addr] <= req_ff.ticket_value;
      end
      common_rd_ff <= common_mem[common_head_ff];
   end

   assign prio_count_ext   = {5'b0, prio_fill_ff};
   assign common_count_ext = {5'b0, common_fill_ff};

   always_comb begin
      rsp_strobe              = rsp_valid_ff;
      rsp_data.status         = rsp_status_ff;
      rsp_data.served_class   = rsp_class_ff;
      rsp_data.served_value   = '0;
      if (rsp_served_ff) begin
         rsp_data.served_value = (rsp_class_ff == CLASS_COMMON) ? common_rd_ff : prio_rd_ff;
      end
      rsp_data.priority_count = prio_count_ext[4:0];
      rsp_data.common_count   = common_count_ext[4:0];
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      prio_fill_ff <= CNT_W'(QUEUE_DEPTH) && common_fill_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_strobe)
      else $error("transaction produced no result");

   a_common_only_when_prio_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_SERVED && rsp_data.served_class == CLASS_COMMON
      |-> rsp_data.priority_count == 5'd0)
      else $error("common ticket served while priority tickets waited");

   a_empty_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_EMPTY
      |-> rsp_data.priority_count == 5'd0 && rsp_data.common_count == 5'd0)
      else $error("empty status with tickets held");

endmodule
